// ===== hw/rtl/mlpq_pkg.sv =====
// mlpq_pkg: shared types and codes for the min leftist priority queue
// no dependencies
`default_nettype none
package mlpq_pkg;
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_DELETE = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// key field width on both channels
	localparam int KEY_FIELD_W = 16;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD_ROOT,
		S_INS_WR,
		S_DEL_RD,
		S_DEL_WAIT,
		S_MELD_START,
		S_WALK_RD,
		S_WALK_CMP,
		S_WALK_LINK,
		S_BACK_RD,
		S_BACK_RANK,
		S_BACK_WR,
		S_MIN_RD,
		S_MIN_WAIT,
		S_DONE
	} state_t;
endpackage
`default_nettype wire

// ===== hw/rtl/mlpq_if.sv =====
// mlpq_if: valid/ready channel carrying one beat of a generic payload
// depends on nothing
`default_nettype none
interface mlpq_if #(
	parameter int W = 8
) (
	input wire logic clk
);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/mlpq_ram.sv =====
// mlpq_ram: generic single write, single read ram with registered read
// depends on nothing
`default_nettype none
module mlpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== hw/rtl/min_leftist_priority_queue_core.sv =====
// min_leftist_priority_queue_core: leftist heap in a node store, one meld sequencer
// a full insert or a delete from an empty queue skips the meld and reports its status
// one item at a time: in.ready is high only while idle and no result waits
// arst_n clears root, count and free list high-water mark; node store needs no clearing
// depends on mlpq_pkg, mlpq_if, mlpq_ram
`default_nettype none
module min_leftist_priority_queue_core #(
	parameter int CAPACITY    = 64,
	parameter int KEY_BITS    = 16,
	parameter int SPINE_DEPTH = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	mlpq_if.sink     in_ch,
	mlpq_if.source   out_ch
);
	localparam int AW = $clog2(CAPACITY);
	localparam int PW = AW + 1;
	localparam int RW = $clog2(AW + 2) + 1;
	localparam int SW = $clog2(SPINE_DEPTH);
	localparam int DW = $clog2(SPINE_DEPTH + 1);
	localparam int NW = KEY_BITS + 2 * PW + RW;
	localparam logic [PW-1:0] NIL = PW'(CAPACITY);

	// node fields packed in one word: key, left, right, rank
	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic [PW-1:0]       left;
		logic [PW-1:0]       right;
		logic [RW-1:0]       rank;
	} node_t;

	mlpq_pkg::state_t state_q, state_d;

	logic [PW-1:0] root_q, x_q, y_q, prev_q, t_q;
	logic [PW:0]   count_q;
	logic          op_q;
	logic [KEY_BITS-1:0] key_q, min_q;
	logic [1:0]    status_q;
	logic [DW-1:0] depth_q;
	logic [AW:0]   fcnt_q;
	logic          out_valid_q;
	node_t         nx_q, ny_q, nb_q;
	logic [RW-1:0] ls_q;
	logic [1:0]    sub_q;

	logic take_first;
	logic last_w;
	logic [PW-1:0] pick_w;
	assign take_first = nx_q.key < ny_q.key;
	assign last_w = (take_first ? nx_q.right : ny_q.right) == NIL;
	assign pick_w = take_first ? x_q : y_q;

	// node ram
	logic          n_we;
	logic [AW-1:0] n_wa, n_ra;
	node_t         n_wd, n_rd;
	mlpq_ram #(.WIDTH(NW), .DEPTH(CAPACITY)) u_nodes (
		.clk(clk), .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(n_ra), .rdata(n_rd));

	// free list
	logic          f_we;
	logic [AW-1:0] f_wa, f_ra, f_rd_raw;
	mlpq_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_free (
		.clk(clk), .we(f_we), .waddr(f_wa), .wdata(root_q[AW-1:0]), .raddr(f_ra),
		.rdata(f_rd_raw));

	// spine stack
	logic          s_we;
	logic [SW-1:0] s_wa, s_ra;
	logic [AW-1:0] s_rd;
	mlpq_ram #(.WIDTH(AW), .DEPTH(SPINE_DEPTH)) u_spine (
		.clk(clk), .we(s_we), .waddr(s_wa), .wdata(pick_w[AW-1:0]), .raddr(s_ra),
		.rdata(s_rd));

	// free stack slot i never written is taken to hold CAPACITY-1-i
	// fcnt_q is the highest count reached; the slot popped is written only below it
	logic [AW-1:0] free_idx;
	logic [AW-1:0] fslot_q;
	assign free_idx = ({1'b0, fcnt_q} > count_q) ? f_rd_raw : AW'(count_q);

	logic [RW-1:0] rs_w;
	assign rs_w = (nb_q.right != NIL) ? n_rd.rank : '0;

	assign in_ch.ready = (state_q == mlpq_pkg::S_IDLE) && !out_valid_q;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data = {status_q, (mlpq_pkg::KEY_FIELD_W)'(min_q), 7'(count_q)};

	always_comb begin
		state_d = state_q;
		case (state_q)
			mlpq_pkg::S_IDLE: if (in_ch.valid && in_ch.ready) state_d = mlpq_pkg::S_RD_ROOT;
			mlpq_pkg::S_RD_ROOT: begin
				if (op_q == mlpq_pkg::OP_INSERT) begin
					if (count_q >= (PW+1)'(CAPACITY)) state_d = mlpq_pkg::S_MIN_RD;
					else state_d = mlpq_pkg::S_INS_WR;
				end else if (root_q == NIL) state_d = mlpq_pkg::S_DONE;
				else state_d = mlpq_pkg::S_DEL_RD;
			end
			mlpq_pkg::S_INS_WR: state_d = mlpq_pkg::S_MELD_START;
			mlpq_pkg::S_DEL_RD: state_d = mlpq_pkg::S_DEL_WAIT;
			mlpq_pkg::S_DEL_WAIT: state_d = mlpq_pkg::S_MELD_START;
			mlpq_pkg::S_MELD_START: begin
				if (x_q == NIL || y_q == NIL) state_d = mlpq_pkg::S_MIN_RD;
				else state_d = mlpq_pkg::S_WALK_RD;
			end
			mlpq_pkg::S_WALK_RD: state_d = (sub_q == 2'd2) ? mlpq_pkg::S_WALK_CMP : state_q;
			mlpq_pkg::S_WALK_CMP: begin
				if (last_w) begin
					if (prev_q != NIL) state_d = mlpq_pkg::S_WALK_LINK;
					else state_d = mlpq_pkg::S_BACK_RD;
				end else state_d = mlpq_pkg::S_WALK_RD;
			end
			mlpq_pkg::S_WALK_LINK: state_d = mlpq_pkg::S_BACK_RD;
			mlpq_pkg::S_BACK_RD: begin
				if (depth_q == '0) state_d = mlpq_pkg::S_MIN_RD;
				else if (sub_q == 2'd3) state_d = mlpq_pkg::S_BACK_RANK;
			end
			mlpq_pkg::S_BACK_RANK: state_d = (sub_q == 2'd1) ? mlpq_pkg::S_BACK_WR : state_q;
			mlpq_pkg::S_BACK_WR: state_d = mlpq_pkg::S_BACK_RD;
			mlpq_pkg::S_MIN_RD: state_d = mlpq_pkg::S_MIN_WAIT;
			mlpq_pkg::S_MIN_WAIT: state_d = mlpq_pkg::S_DONE;
			mlpq_pkg::S_DONE: state_d = mlpq_pkg::S_IDLE;
			default: state_d = mlpq_pkg::S_IDLE;
		endcase
	end

	// memory ports
	always_comb begin
		n_we = 1'b0; n_wa = t_q[AW-1:0]; n_wd = nx_q; n_ra = root_q[AW-1:0];
		f_we = 1'b0;
		f_wa = AW'((PW+1)'(CAPACITY) - count_q);
		f_ra = fslot_q;
		s_we = 1'b0; s_wa = SW'(depth_q); s_ra = SW'(depth_q - 1'b1);
		case (state_q)
			mlpq_pkg::S_INS_WR: begin
				n_we = 1'b1; n_wa = free_idx;
				n_wd = '{key: key_q, left: NIL, right: NIL, rank: RW'(1)};
			end
			mlpq_pkg::S_DEL_RD: begin
				f_we = 1'b1;
			end
			mlpq_pkg::S_WALK_RD: begin
				n_ra = (sub_q == 2'd0) ? x_q[AW-1:0] : y_q[AW-1:0];
			end
			mlpq_pkg::S_WALK_CMP: begin
				// link chosen node as right child of previous; on the last step give the chosen node the other tree as its right
				if (last_w) begin
					n_we = 1'b1;
					n_wa = take_first ? x_q[AW-1:0] : y_q[AW-1:0];
					n_wd = take_first ? nx_q : ny_q;
					n_wd.right = take_first ? y_q : x_q;
				end else if (prev_q != NIL) begin
					n_we = 1'b1; n_wa = prev_q[AW-1:0]; n_wd = nb_q;
					n_wd.right = take_first ? x_q : y_q;
				end
				s_we = (depth_q < DW'(SPINE_DEPTH));
				s_wa = SW'(depth_q);
			end
			mlpq_pkg::S_WALK_LINK: begin
				n_we = 1'b1; n_wa = prev_q[AW-1:0]; n_wd = nb_q;
				n_wd.right = t_q;
			end
			mlpq_pkg::S_BACK_RD: begin
				n_ra = s_rd;
			end
			mlpq_pkg::S_BACK_RANK: begin
				n_ra = (sub_q == 2'd0) ? nb_q.left[AW-1:0] : nb_q.right[AW-1:0];
			end
			mlpq_pkg::S_BACK_WR: begin
				n_we = 1'b1; n_wa = t_q[AW-1:0]; n_wd = nb_q;
				if (rs_w > ls_q) begin
					n_wd.left = nb_q.right; n_wd.right = nb_q.left;
					n_wd.rank = (nb_q.left != NIL) ? ls_q + 1'b1 : RW'(1);
				end else begin
					n_wd.rank = (nb_q.right != NIL) ? rs_w + 1'b1 : RW'(1);
				end
			end
			mlpq_pkg::S_MIN_RD: n_ra = root_q[AW-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mlpq_pkg::S_IDLE;
			root_q <= NIL;
			count_q <= '0;
			fcnt_q <= '0;
			out_valid_q <= 1'b0;
			sub_q <= '0;
			depth_q <= '0;
		end else begin
			state_q <= state_d;
			if (out_ch.valid && out_ch.ready) out_valid_q <= 1'b0;
			case (state_q)
				mlpq_pkg::S_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						op_q <= in_ch.data[mlpq_pkg::KEY_FIELD_W];
						key_q <= in_ch.data[KEY_BITS-1:0];
						status_q <= mlpq_pkg::ST_OK;
						min_q <= '0;
						fslot_q <= AW'(CAPACITY - 1) - AW'(count_q);
					end
				end
				mlpq_pkg::S_RD_ROOT: begin
					if (op_q == mlpq_pkg::OP_INSERT && count_q >= (PW+1)'(CAPACITY))
						status_q <= mlpq_pkg::ST_FULL;
					else if (op_q == mlpq_pkg::OP_DELETE && root_q == NIL)
						status_q <= mlpq_pkg::ST_EMPTY;
					fslot_q <= AW'((PW+1)'(CAPACITY) - count_q - 1'b1);
				end
				mlpq_pkg::S_INS_WR: begin
					x_q <= root_q; y_q <= {1'b0, free_idx};
					count_q <= count_q + 1'b1;
					if ({1'b0, fcnt_q} == count_q) fcnt_q <= fcnt_q + 1'b1;
				end
				mlpq_pkg::S_DEL_RD: begin
					count_q <= count_q - 1'b1;
				end
				mlpq_pkg::S_DEL_WAIT: begin
					min_q <= n_rd.key; x_q <= n_rd.left; y_q <= n_rd.right;
				end
				mlpq_pkg::S_MELD_START: begin
					prev_q <= NIL; depth_q <= '0; sub_q <= '0;
					root_q <= (x_q == NIL) ? y_q : x_q;
				end
				mlpq_pkg::S_WALK_RD: begin
					sub_q <= sub_q + 1'b1;
					if (sub_q == 2'd1) nx_q <= n_rd;
					if (sub_q == 2'd2) begin
						ny_q <= n_rd; sub_q <= '0;
					end
				end
				mlpq_pkg::S_WALK_CMP: begin
					t_q <= pick_w;
					if (prev_q == NIL) root_q <= pick_w;
					if (depth_q < DW'(SPINE_DEPTH)) depth_q <= depth_q + 1'b1;
					if (!last_w) begin
						prev_q <= pick_w;
						nb_q <= take_first ? nx_q : ny_q;
					end
					if (take_first) x_q <= nx_q.right; else y_q <= ny_q.right;
					sub_q <= '0;
				end
				mlpq_pkg::S_BACK_RD: begin
					sub_q <= sub_q + 1'b1;
					if (sub_q == 2'd1) t_q <= {1'b0, s_rd};
					if (sub_q == 2'd3) begin
						nb_q <= n_rd; depth_q <= depth_q - 1'b1; sub_q <= '0;
					end
				end
				mlpq_pkg::S_BACK_RANK: begin
					sub_q <= sub_q + 1'b1;
					if (sub_q == 2'd1) begin
						ls_q <= (nb_q.left != NIL) ? n_rd.rank : '0;
						sub_q <= '0;
					end
				end
				mlpq_pkg::S_MIN_WAIT: begin
					if (op_q == mlpq_pkg::OP_INSERT && root_q != NIL) min_q <= n_rd.key;
				end
				mlpq_pkg::S_DONE: out_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire
